FILE: rtl/mlbc_pkg.sv
// Shared types, codes and constants for the multi-LED blink controller.
`default_nettype none
package mlbc_pkg;

	// Parameter defaults
	localparam int NUM_LEDS_DEF    = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	// Configuration register file
	localparam int CFG_W   = 16;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 4;
	localparam int EXT_W   = 32;

	localparam logic [1:0] REG_ON_TICKS       = 2'd0;
	localparam logic [1:0] REG_FAST_OFF_TICKS = 2'd1;
	localparam logic [1:0] REG_SLOW_OFF_TICKS = 2'd2;

	localparam logic [CFG_W-1:0] ON_TICKS_RST       = 16'd250;
	localparam logic [CFG_W-1:0] FAST_OFF_TICKS_RST = 16'd500;
	localparam logic [CFG_W-1:0] SLOW_OFF_TICKS_RST = 16'd1000;

	// Payload widths
	localparam int REQ_W  = 2;
	localparam int IDX_W  = 3;
	localparam int MODE_W = 2;
	localparam int PIN_W  = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK       = 2'd0,
		REQ_SET_MODE   = 2'd1,
		REQ_SHOW_BYTE  = 2'd2,
		REQ_CLEAR_BYTE = 2'd3
	} req_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ON   = 2'd0,
		MODE_OFF  = 2'd1,
		MODE_SLOW = 2'd2,
		MODE_FAST = 2'd3
	} mode_t;

	// Per-lane command from the request decode
	typedef struct packed {
		logic  tick;
		logic  set;
		mode_t mode;
	} lane_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/mlbc_lane.sv
// One LED channel: mode register, on/off counters and the pin level it drives.
`default_nettype none
module mlbc_lane #(
	parameter int COUNT_WIDTH = mlbc_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mlbc_pkg::lane_cmd_t    cmd,
	input  wire logic [COUNT_WIDTH-1:0] on_load,
	input  wire logic [COUNT_WIDTH-1:0] slow_load,
	input  wire logic [COUNT_WIDTH-1:0] fast_load,
	output logic                        level
);

	mlbc_pkg::mode_t        mode_q;
	logic [COUNT_WIDTH-1:0] on_cnt_q;
	logic [COUNT_WIDTH-1:0] off_cnt_q;
	logic                   blinking;
	logic                   new_blinking;
	logic                   on_zero;
	logic                   off_zero;

	assign on_zero      = (on_cnt_q == '0);
	assign off_zero     = (off_cnt_q == '0);
	assign blinking     = (mode_q == mlbc_pkg::MODE_SLOW) || (mode_q == mlbc_pkg::MODE_FAST);
	assign new_blinking = (cmd.mode == mlbc_pkg::MODE_SLOW) ||
	                      (cmd.mode == mlbc_pkg::MODE_FAST);

	// Level driven on a tick, from the state before the update
	always_comb begin
		unique case (mode_q)
			mlbc_pkg::MODE_ON:   level = 1'b1;
			mlbc_pkg::MODE_OFF:  level = 1'b0;
			mlbc_pkg::MODE_SLOW,
			mlbc_pkg::MODE_FAST: level = !on_zero || off_zero;
			default:             level = 1'b0;
		endcase
	end

	// Mode and counters: load on set, count down on tick, reload at end of off phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= mlbc_pkg::MODE_OFF;
			on_cnt_q  <= '0;
			off_cnt_q <= '0;
		end else begin
			priority if (cmd.set) begin
				mode_q <= cmd.mode;
				if (new_blinking) begin
					on_cnt_q  <= on_load;
					off_cnt_q <= (cmd.mode == mlbc_pkg::MODE_SLOW) ? slow_load : fast_load;
				end
			end else if (cmd.tick && blinking) begin
				priority if (!on_zero) begin
					on_cnt_q <= on_cnt_q - COUNT_WIDTH'(1);
				end else if (!off_zero) begin
					off_cnt_q <= off_cnt_q - COUNT_WIDTH'(1);
				end else begin
					on_cnt_q  <= on_load;
					off_cnt_q <= (mode_q == mlbc_pkg::MODE_SLOW) ? slow_load : fast_load;
				end
			end else begin
				mode_q <= mode_q;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/multi_led_blink_controller_core.sv
// Top level of the multi-LED blink controller: input stage, lanes, pin and config registers.
// Path: a transferred request goes through the input register, then the pin register;
//   the pin register doubles as the result register and is loaded when the output is free.
// Throughput: one request per cycle while the output is free (not stalled by out_ready).
// Reset: arst_n clears the pipeline, all modes to steady off, counters, override and pins,
//   and loads the blink period registers with their defaults; no clearing pass.
`default_nettype none
module multi_led_blink_controller_core #(
	parameter int NUM_LEDS    = mlbc_pkg::NUM_LEDS_DEF,
	parameter int COUNT_WIDTH = mlbc_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mlbc_pkg::REQ_W-1:0]    req_type,
	input  wire logic [mlbc_pkg::IDX_W-1:0]    led_index,
	input  wire logic [mlbc_pkg::MODE_W-1:0]   led_mode,
	input  wire logic [mlbc_pkg::PIN_W-1:0]    byte_value,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mlbc_pkg::PIN_W-1:0]         led_pins,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mlbc_pkg::APB_AW-1:0]   paddr,
	input  wire logic [mlbc_pkg::APB_DW-1:0]   pwdata,
	output logic [mlbc_pkg::APB_DW-1:0]        prdata,
	output logic                               pready
);

	localparam int PW = mlbc_pkg::PIN_W;

	// Configuration registers
	logic [mlbc_pkg::CFG_W-1:0] on_ticks_q;
	logic [mlbc_pkg::CFG_W-1:0] fast_off_ticks_q;
	logic [mlbc_pkg::CFG_W-1:0] slow_off_ticks_q;
	logic                       cfg_wr;
	logic [1:0]                 cfg_sel;

	// Input stage
	logic                           valid_s1;
	logic [mlbc_pkg::REQ_W-1:0]     req_type_s1;
	logic [mlbc_pkg::IDX_W-1:0]     led_index_s1;
	logic [mlbc_pkg::MODE_W-1:0]    led_mode_s1;
	logic [PW-1:0]                  byte_value_s1;
	mlbc_pkg::req_t                 req_s1;

	// Result / state
	logic          out_valid_q;
	logic          override_q;
	logic [PW-1:0] pins_q;
	logic [PW-1:0] pins_next;
	logic          advance;
	logic          tick_go;
	logic          set_go;

	logic [mlbc_pkg::EXT_W-1:0] on_ext;
	logic [mlbc_pkg::EXT_W-1:0] slow_ext;
	logic [mlbc_pkg::EXT_W-1:0] fast_ext;
	logic [COUNT_WIDTH-1:0]     on_load;
	logic [COUNT_WIDTH-1:0]     slow_load;
	logic [COUNT_WIDTH-1:0]     fast_load;

	logic [NUM_LEDS-1:0] lane_level;
	logic [PW-1:0]       tick_bits;
	logic [PW-1:0]       tick_mask;

	// APB register writes and reads
	assign pready  = 1'b1;
	assign cfg_sel = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_ticks_q       <= mlbc_pkg::ON_TICKS_RST;
			fast_off_ticks_q <= mlbc_pkg::FAST_OFF_TICKS_RST;
			slow_off_ticks_q <= mlbc_pkg::SLOW_OFF_TICKS_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				mlbc_pkg::REG_ON_TICKS:       on_ticks_q       <= pwdata[mlbc_pkg::CFG_W-1:0];
				mlbc_pkg::REG_FAST_OFF_TICKS: fast_off_ticks_q <= pwdata[mlbc_pkg::CFG_W-1:0];
				mlbc_pkg::REG_SLOW_OFF_TICKS: slow_off_ticks_q <= pwdata[mlbc_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			mlbc_pkg::REG_ON_TICKS:       prdata = mlbc_pkg::APB_DW'(on_ticks_q);
			mlbc_pkg::REG_FAST_OFF_TICKS: prdata = mlbc_pkg::APB_DW'(fast_off_ticks_q);
			mlbc_pkg::REG_SLOW_OFF_TICKS: prdata = mlbc_pkg::APB_DW'(slow_off_ticks_q);
			default:                      prdata = '0;
		endcase
	end

	// Counter reload values, taken modulo 2^COUNT_WIDTH
	assign on_ext    = mlbc_pkg::EXT_W'(on_ticks_q);
	assign slow_ext  = mlbc_pkg::EXT_W'(slow_off_ticks_q);
	assign fast_ext  = mlbc_pkg::EXT_W'(fast_off_ticks_q);
	assign on_load   = on_ext[COUNT_WIDTH-1:0];
	assign slow_load = slow_ext[COUNT_WIDTH-1:0];
	assign fast_load = fast_ext[COUNT_WIDTH-1:0];

	// Handshake: stage 1 moves into the pin register when the output is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign led_pins  = pins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1   <= req_type;
			led_index_s1  <= led_index;
			led_mode_s1   <= led_mode;
			byte_value_s1 <= byte_value;
		end
	end

	assign req_s1  = mlbc_pkg::req_t'(req_type_s1);
	assign tick_go = advance && (req_s1 == mlbc_pkg::REQ_TICK) && !override_q;
	assign set_go  = advance && (req_s1 == mlbc_pkg::REQ_SET_MODE);

	// LED lanes
	for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
		mlbc_pkg::lane_cmd_t lane_cmd;

		assign lane_cmd.tick = tick_go;
		assign lane_cmd.set  = set_go && (32'(led_index_s1) == i);
		assign lane_cmd.mode = mlbc_pkg::mode_t'(led_mode_s1);

		mlbc_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (lane_cmd),
			.on_load   (on_load),
			.slow_load (slow_load),
			.fast_load (fast_load),
			.level     (lane_level[i])
		);
	end

	// Map lane levels onto the visible pin byte
	for (genvar p = 0; p < PW; p++) begin : g_pin
		if (p < NUM_LEDS) begin : g_used
			assign tick_bits[p] = lane_level[p];
			assign tick_mask[p] = 1'b1;
		end else begin : g_unused
			assign tick_bits[p] = 1'b0;
			assign tick_mask[p] = 1'b0;
		end
	end

	// Next pin byte for the request in stage 1
	always_comb begin
		pins_next = pins_q;
		unique case (req_s1)
			mlbc_pkg::REQ_TICK: begin
				if (!override_q) begin
					pins_next = (pins_q & ~tick_mask) | (tick_bits & tick_mask);
				end
			end
			mlbc_pkg::REQ_SHOW_BYTE:  pins_next = byte_value_s1;
			mlbc_pkg::REQ_SET_MODE,
			mlbc_pkg::REQ_CLEAR_BYTE: pins_next = pins_q;
			default:                  pins_next = pins_q;
		endcase
	end

	// Pin register, override flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			override_q  <= 1'b0;
			pins_q      <= '0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			pins_q      <= pins_next;
			if (req_s1 == mlbc_pkg::REQ_SHOW_BYTE) begin
				override_q <= 1'b1;
			end else if (req_s1 == mlbc_pkg::REQ_CLEAR_BYTE) begin
				override_q <= 1'b0;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mlbc_checker.sv
// Port-level checker for the multi-LED blink controller, bound to the top level.
`default_nettype none
module mlbc_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic [mlbc_pkg::REQ_W-1:0]   req_type,
	input wire logic [mlbc_pkg::PIN_W-1:0]   byte_value,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [mlbc_pkg::PIN_W-1:0]   led_pins
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(led_pins))
		else $error("result changed while stalled");

	// With no result pending the input side is never blocked
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A shown byte reaches the pins through the input and pin registers when the output is not stalled
	a_show_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == mlbc_pkg::REQ_SHOW_BYTE) ##1 out_ready
		|=> out_valid && (led_pins == $past(byte_value, 2)))
		else $error("shown byte not on pins");

	// Set-mode and clear-byte transfers leave the pin byte as it was
	a_no_pin_change: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && ((req_type == mlbc_pkg::REQ_SET_MODE) ||
		(req_type == mlbc_pkg::REQ_CLEAR_BYTE)) ##1 out_ready
		|=> out_valid && $stable(led_pins))
		else $error("pins changed by set mode or clear byte");

endmodule

bind multi_led_blink_controller_core mlbc_checker u_mlbc_checker (.*);
`default_nettype wire
